[design/uart_fifo_xon_xoff_channel_assert.svh]
// ----------------------------------------------------------------------------
// UART XON/XOFF channel assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef UART_FIFO_XON_XOFF_CHANNEL_ASSERT_SVH
`define UART_FIFO_XON_XOFF_CHANNEL_ASSERT_SVH

`ifndef SYNTHESIS

`define UFX_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

`define UFX_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define UFX_ASSERT_SAME(lbl, clk, rstn, ante, cons)

`define UFX_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

[design/ufx_pkg.sv]
// ----------------------------------------------------------------------------
// UART XON/XOFF channel package
// Shared types and constants for controller, datapath and top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ufx_pkg;

    localparam int XOFF_W    = 7;
    localparam int XON_W     = 6;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 7;
    localparam int FILL_W    = 7;

    localparam logic [XOFF_W-1:0] XOFF_RESET = 7'd48;
    localparam logic [XON_W-1:0]  XON_RESET  = 6'd16;

    localparam logic [CFG_IDX_W-1:0] CFG_XOFF = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_XON  = 2'd1;

    localparam logic [7:0] CH_XOFF    = 8'h13;
    localparam logic [7:0] CH_XON     = 8'h11;
    localparam logic [7:0] MASK7      = 8'h7F;
    localparam logic [7:0] EMPTY_READ = 8'hFF;

    typedef enum logic [1:0] {
        KIND_LINE  = 2'd0,
        KIND_TXE   = 2'd1,
        KIND_READ  = 2'd2,
        KIND_WRITE = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        FLOW_NONE = 2'd0,
        FLOW_S    = 2'd1,
        FLOW_Q    = 2'd2
    } t_flow;

    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic capture;
        logic exec;
    } t_cmd;

endpackage

`default_nettype wire

[design/ufx_ctrl.sv]
// ----------------------------------------------------------------------------
// UART XON/XOFF channel controller
// Sequences capture and execute of one transaction and owns output valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ufx_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output ufx_pkg::t_cmd      o_cmd
);
    import ufx_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall  = 1'b0;
                o_cmd.capture = i_in_valid;
            end
            ST_EXEC: begin
                o_cmd.exec = out_free;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.exec) begin
            n_out_valid = 1'b1;
        end else begin
            n_out_valid = r_out_valid && i_out_stall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

[design/ufx_datapath.sv]
// ----------------------------------------------------------------------------
// UART XON/XOFF channel datapath
// Receive and transmit rings, flow control flags, config and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ufx_datapath #(
    parameter int RX_DEPTH = 64,
    parameter int TX_DEPTH = 64
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire ufx_pkg::t_cmd                  i_cmd,
    input  wire logic                           i_cfg_we,
    input  wire logic [ufx_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [ufx_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    input  wire logic [1:0]                     i_kind,
    input  wire logic [7:0]                     i_data_byte,
    input  wire logic [3:0]                     i_line_errors,
    output logic                                o_line_send,
    output logic [7:0]                          o_line_byte,
    output logic                                o_read_ok,
    output logic [7:0]                          o_read_byte,
    output logic                                o_write_ok,
    output logic [ufx_pkg::FILL_W-1:0]          o_rx_fill,
    output logic [ufx_pkg::FILL_W-1:0]          o_tx_space,
    output logic                                o_rx_overflow,
    output logic                                o_spurious_event,
    output logic [3:0]                          o_error_bits,
    output logic                                o_peer_stopped
);
    import ufx_pkg::*;

    localparam int RX_PW   = $clog2(RX_DEPTH);
    localparam int TX_PW   = $clog2(TX_DEPTH);
    localparam int RX_CW   = $clog2(RX_DEPTH + 1);
    localparam int TX_CW   = $clog2(TX_DEPTH + 1);
    localparam int RX_CMPW = (RX_CW > XOFF_W) ? RX_CW : XOFF_W;

    localparam logic [RX_PW-1:0] RX_LAST = RX_PW'(RX_DEPTH - 1);
    localparam logic [TX_PW-1:0] TX_LAST = TX_PW'(TX_DEPTH - 1);
    localparam logic [RX_CW-1:0] RX_FULL = RX_CW'(RX_DEPTH);
    localparam logic [TX_CW-1:0] TX_FULL = TX_CW'(TX_DEPTH);

    // config
    logic [XOFF_W-1:0] r_xoff_level;
    logic [XON_W-1:0]  r_xon_level;

    // captured transaction
    t_kind      r_kind;
    logic [7:0] r_byte;
    logic [3:0] r_errs;

    // rings
    logic [7:0]       r_rx_mem [RX_DEPTH];
    logic [7:0]       r_tx_mem [TX_DEPTH];
    logic [7:0]       r_rx_rd;
    logic [7:0]       r_tx_rd;
    logic [RX_PW-1:0] r_rx_head, n_rx_head, r_rx_tail, n_rx_tail;
    logic [TX_PW-1:0] r_tx_head, n_tx_head, r_tx_tail, n_tx_tail;
    logic [RX_CW-1:0] r_rx_count, n_rx_count;
    logic [TX_CW-1:0] r_tx_count, n_tx_count;
    logic             rx_we, tx_we;

    // flags
    t_flow      r_pending, n_pending;
    logic       r_hyst, n_hyst;
    logic       r_peer_stop, n_peer_stop;
    logic       r_txen, n_txen;
    logic       r_ovf, n_ovf;
    logic       r_spur, n_spur;
    logic [3:0] r_lerr, n_lerr;

    // result fields
    logic       n_send, n_rok, n_wok;
    logic [7:0] n_sbyte, n_rbyte;

    always_comb begin
        n_rx_head   = r_rx_head;
        n_rx_tail   = r_rx_tail;
        n_rx_count  = r_rx_count;
        n_tx_head   = r_tx_head;
        n_tx_tail   = r_tx_tail;
        n_tx_count  = r_tx_count;
        n_pending   = r_pending;
        n_hyst      = r_hyst;
        n_peer_stop = r_peer_stop;
        n_txen      = r_txen;
        n_ovf       = r_ovf;
        n_spur      = r_spur;
        n_lerr      = r_lerr;
        rx_we       = 1'b0;
        tx_we       = 1'b0;
        n_send      = 1'b0;
        n_sbyte     = '0;
        n_rok       = 1'b0;
        n_rbyte     = '0;
        n_wok       = 1'b0;
        unique case (r_kind)
            KIND_LINE: begin
                n_lerr = r_errs;
                if (r_errs != 4'd0) begin
                    n_spur = 1'b1;
                end else if (r_byte == CH_XOFF) begin
                    n_txen      = 1'b0;
                    n_peer_stop = 1'b1;
                end else if (r_byte == CH_XON) begin
                    n_peer_stop = 1'b0;
                    n_txen      = 1'b1;
                end else if (r_rx_count == RX_FULL) begin
                    n_ovf = 1'b1;
                end else begin
                    rx_we      = 1'b1;
                    n_rx_head  = (r_rx_head == RX_LAST) ? '0 : r_rx_head + 1'b1;
                    n_rx_count = r_rx_count + 1'b1;
                    if (RX_CMPW'(n_rx_count) >= RX_CMPW'(r_xoff_level)) begin
                        n_pending = FLOW_S;
                        n_hyst    = 1'b1;
                        n_txen    = 1'b1;
                    end
                end
            end
            KIND_TXE: begin
                n_lerr = 4'd0;
                if (!r_txen) begin
                    n_spur = 1'b1;
                end else if (r_pending == FLOW_S || r_pending == FLOW_Q) begin
                    n_send    = 1'b1;
                    n_sbyte   = (r_pending == FLOW_S) ? CH_XOFF : CH_XON;
                    n_pending = FLOW_NONE;
                end else if (r_tx_count == '0 || r_peer_stop) begin
                    n_txen = 1'b0;
                end else begin
                    n_send     = 1'b1;
                    n_sbyte    = r_tx_rd & MASK7;
                    n_tx_tail  = (r_tx_tail == TX_LAST) ? '0 : r_tx_tail + 1'b1;
                    n_tx_count = r_tx_count - 1'b1;
                end
            end
            KIND_READ: begin
                if (r_rx_count == '0) begin
                    n_rbyte = EMPTY_READ;
                end else begin
                    n_rok      = 1'b1;
                    n_rbyte    = r_rx_rd;
                    n_rx_tail  = (r_rx_tail == RX_LAST) ? '0 : r_rx_tail + 1'b1;
                    n_rx_count = r_rx_count - 1'b1;
                    if (r_hyst && (RX_CMPW'(n_rx_count) <= RX_CMPW'(r_xon_level))) begin
                        n_pending = FLOW_Q;
                        n_hyst    = 1'b0;
                        n_txen    = 1'b1;
                    end
                end
            end
            KIND_WRITE: begin
                if (r_tx_count != TX_FULL) begin
                    n_wok      = 1'b1;
                    tx_we      = 1'b1;
                    n_tx_head  = (r_tx_head == TX_LAST) ? '0 : r_tx_head + 1'b1;
                    n_tx_count = r_tx_count + 1'b1;
                    if (!r_peer_stop) begin
                        n_txen = 1'b1;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xoff_level <= XOFF_RESET;
            r_xon_level  <= XON_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_XOFF) begin
                r_xoff_level <= i_cfg_data;
            end else if (i_cfg_index == CFG_XON) begin
                r_xon_level <= i_cfg_data[XON_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind <= t_kind'(i_kind);
            r_byte <= i_data_byte;
            r_errs <= i_line_errors;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && rx_we) begin
            r_rx_mem[r_rx_head] <= r_byte;
        end
        if (i_cmd.capture) begin
            r_rx_rd <= r_rx_mem[r_rx_tail];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && tx_we) begin
            r_tx_mem[r_tx_head] <= r_byte;
        end
        if (i_cmd.capture) begin
            r_tx_rd <= r_tx_mem[r_tx_tail];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_head   <= '0;
            r_rx_tail   <= '0;
            r_rx_count  <= '0;
            r_tx_head   <= '0;
            r_tx_tail   <= '0;
            r_tx_count  <= '0;
            r_pending   <= FLOW_NONE;
            r_hyst      <= 1'b0;
            r_peer_stop <= 1'b0;
            r_txen      <= 1'b0;
            r_ovf       <= 1'b0;
            r_spur      <= 1'b0;
            r_lerr      <= 4'd0;
        end else if (i_cmd.exec) begin
            r_rx_head   <= n_rx_head;
            r_rx_tail   <= n_rx_tail;
            r_rx_count  <= n_rx_count;
            r_tx_head   <= n_tx_head;
            r_tx_tail   <= n_tx_tail;
            r_tx_count  <= n_tx_count;
            r_pending   <= n_pending;
            r_hyst      <= n_hyst;
            r_peer_stop <= n_peer_stop;
            r_txen      <= n_txen;
            r_ovf       <= n_ovf;
            r_spur      <= n_spur;
            r_lerr      <= n_lerr;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            o_line_send      <= n_send;
            o_line_byte      <= n_sbyte;
            o_read_ok        <= n_rok;
            o_read_byte      <= n_rbyte;
            o_write_ok       <= n_wok;
            o_rx_fill        <= FILL_W'(n_rx_count);
            o_tx_space       <= FILL_W'(TX_FULL - n_tx_count);
            o_rx_overflow    <= n_ovf;
            o_spurious_event <= n_spur;
            o_error_bits     <= n_lerr;
            o_peer_stopped   <= n_peer_stop;
        end
    end

endmodule

`default_nettype wire

[design/uart_fifo_xon_xoff_channel.sv]
// ----------------------------------------------------------------------------
// UART XON/XOFF channel
// Receive/transmit rings with software flow control, one event per transaction.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  in        input      i_in_valid / o_in_stall   i_kind, i_data_byte, i_line_errors
//  out       output     o_out_valid / i_out_stall o_line_send .. o_peer_stopped
//  cfg       input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
//  Each event has a capture step (ring read port registers the oldest
//  entry) and an execute step. A new event is accepted while a result waits.
//  Reset is synchronous, active low; ring contents are not cleared.
//  Execute holds while the result register is full and stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "uart_fifo_xon_xoff_channel_assert.svh"

module uart_fifo_xon_xoff_channel #(
    parameter int RX_DEPTH = 64,
    parameter int TX_DEPTH = 64
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [1:0]                     i_kind,
    input  wire logic [7:0]                     i_data_byte,
    input  wire logic [3:0]                     i_line_errors,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic                                o_line_send,
    output logic [7:0]                          o_line_byte,
    output logic                                o_read_ok,
    output logic [7:0]                          o_read_byte,
    output logic                                o_write_ok,
    output logic [ufx_pkg::FILL_W-1:0]          o_rx_fill,
    output logic [ufx_pkg::FILL_W-1:0]          o_tx_space,
    output logic                                o_rx_overflow,
    output logic                                o_spurious_event,
    output logic [3:0]                          o_error_bits,
    output logic                                o_peer_stopped,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [ufx_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [ufx_pkg::CFG_DAT_W-1:0]  i_cfg_data
);
    import ufx_pkg::*;

    t_cmd cmd;

    assign o_cfg_ready = 1'b1;

    ufx_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    ufx_datapath #(
        .RX_DEPTH (RX_DEPTH),
        .TX_DEPTH (TX_DEPTH)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_cfg_we         (i_cfg_valid && o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_kind           (i_kind),
        .i_data_byte      (i_data_byte),
        .i_line_errors    (i_line_errors),
        .o_line_send      (o_line_send),
        .o_line_byte      (o_line_byte),
        .o_read_ok        (o_read_ok),
        .o_read_byte      (o_read_byte),
        .o_write_ok       (o_write_ok),
        .o_rx_fill        (o_rx_fill),
        .o_tx_space       (o_tx_space),
        .o_rx_overflow    (o_rx_overflow),
        .o_spurious_event (o_spurious_event),
        .o_error_bits     (o_error_bits),
        .o_peer_stopped   (o_peer_stopped)
    );

    `UFX_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    `UFX_ASSERT_NEXT(a_exec_result, i_clk, i_rst_n, cmd.exec, o_out_valid)
    `UFX_ASSERT_SAME(a_cmd_excl, i_clk, i_rst_n, 1'b1, !(cmd.capture && cmd.exec))
    `UFX_ASSERT_SAME(a_one_action, i_clk, i_rst_n, o_out_valid,
                     $onehot0({o_line_send, o_read_ok, o_write_ok}))

endmodule

`default_nettype wire
